// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, quiet during reset
`define BDA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication, quiet during reset
`define BDA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/bda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// shared types and constants of the button debounce / autorepeat block
// ----------------------------------------------------------------------------
package bda_pkg;

   localparam int NUM_BUTTONS = 5;
   localparam int TIME_W      = 32;
   localparam int MS_CFG_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int EVENT_W     = $clog2(NUM_BUTTONS + 1);

   localparam logic [EVENT_W-1:0] NO_EVENT = EVENT_W'(NUM_BUTTONS);

   typedef enum logic [1:0] {
      CSR_DEBOUNCE_TIME  = 2'd0,
      CSR_REPEAT_DELAY   = 2'd1,
      CSR_REPEAT_PERIOD  = 2'd2,
      CSR_REPEAT_ENABLE  = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACT_UPDATE = 1'b0,
      ACT_PROBE  = 1'b1
   } action_type;

   // timing settings seen by every lane
   typedef struct packed {
      logic [MS_CFG_W-1:0] debounce_time;
      logic [MS_CFG_W-1:0] repeat_delay;
      logic [MS_CFG_W-1:0] repeat_period;
   } timing_type;

   // what one lane reports for the item it just took
   typedef struct packed {
      logic fire;
      logic down;
      logic locked;
   } lane_status_type;

endpackage

// File: rtl/bda_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_lane
// debounce, autorepeat and startup lock state of one button
// ----------------------------------------------------------------------------
module bda_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            update,
   input  bda_pkg::action_type             action,
   input  logic                            raw,
   input  logic [bda_pkg::TIME_W-1:0]      now_ms,
   input  bda_pkg::timing_type             timing,
   input  logic                            repeat_en,
   output bda_pkg::lane_status_type        status
);

   logic                         stable_ff, stable_in;
   logic                         last_raw_ff, last_raw_in;
   logic                         locked_ff, locked_in;
   logic [bda_pkg::TIME_W-1:0]   change_time_ff, change_time_in;
   logic [bda_pkg::TIME_W-1:0]   repeat_time_ff, repeat_time_in;
   logic [bda_pkg::TIME_W-1:0]   age;
   logic                         aged;
   logic                         fire;

   assign age  = now_ms - change_time_ff;
   assign aged = age >= {{(bda_pkg::TIME_W - bda_pkg::MS_CFG_W){1'b0}}, timing.debounce_time};

   always_comb begin
      stable_in      = stable_ff;
      last_raw_in    = last_raw_ff;
      locked_in      = locked_ff;
      change_time_in = change_time_ff;
      repeat_time_in = repeat_time_ff;
      fire           = 1'b0;
      if (action == bda_pkg::ACT_PROBE) begin
         if (raw) begin
            locked_in   = 1'b1;
            last_raw_in = 1'b1;
         end
      end else if (raw != last_raw_ff) begin
         // edge seen: only note the new level and the time
         last_raw_in    = raw;
         change_time_in = now_ms;
      end else if (aged) begin
         if (locked_ff) begin
            if (!raw) locked_in = 1'b0;
         end else if (raw && !stable_ff) begin
            stable_in      = 1'b1;
            repeat_time_in = now_ms + {{(bda_pkg::TIME_W - bda_pkg::MS_CFG_W){1'b0}},
                                       timing.repeat_delay};
            fire           = 1'b1;
         end else if (!raw && stable_ff) begin
            stable_in = 1'b0;
         end else if (raw && stable_ff && repeat_en && (now_ms >= repeat_time_ff)) begin
            // plain compare, no wrap
            repeat_time_in = now_ms + {{(bda_pkg::TIME_W - bda_pkg::MS_CFG_W){1'b0}},
                                       timing.repeat_period};
            fire           = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b0;
         last_raw_ff    <= 1'b0;
         locked_ff      <= 1'b0;
         change_time_ff <= '0;
         repeat_time_ff <= '0;
      end else if (update) begin
         stable_ff      <= stable_in;
         last_raw_ff    <= last_raw_in;
         locked_ff      <= locked_in;
         change_time_ff <= change_time_in;
         repeat_time_ff <= repeat_time_in;
      end
   end

   assign status.fire   = fire;
   assign status.down   = stable_in & ~locked_in;
   assign status.locked = locked_in;

endmodule

// File: rtl/button_debounce_autorepeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// debounce, autorepeat and startup lock for a small set of buttons
// ----------------------------------------------------------------------------
// Takes one item per clock while req_stall is low and returns one result per
// item. The item goes through the input register and then the result
// register, and its result stays on the rsp_ port until the receiver takes
// it. Every button lane works side by side on the registered item, so
// throughput is one item per cycle and is set only by the output side:
// req_stall rises when an item sits in the input register and the result
// register is full and stalled. Settings are to be written through the csr_
// port only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_debounce_autorepeat (
   input  logic                                  clock,
   input  logic                                  reset,
   // settings write port
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [bda_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // item input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [bda_pkg::NUM_BUTTONS-1:0]       req_raw_pressed,
   input  logic [bda_pkg::TIME_W-1:0]            req_now_ms,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bda_pkg::EVENT_W-1:0]           rsp_event_button,
   output logic [bda_pkg::NUM_BUTTONS-1:0]       rsp_down_mask,
   output logic [bda_pkg::NUM_BUTTONS-1:0]       rsp_locked_mask
);

   // settings registers
   bda_pkg::timing_type                  timing_ff;
   logic [bda_pkg::NUM_BUTTONS-1:0]      repeat_en_ff;

   // input register
   logic                                 s1_valid_ff;
   bda_pkg::action_type                  s1_action_ff;
   logic [bda_pkg::NUM_BUTTONS-1:0]      s1_raw_ff;
   logic [bda_pkg::TIME_W-1:0]           s1_now_ff;

   // result register
   logic                                 rsp_valid_ff;
   logic [bda_pkg::EVENT_W-1:0]          event_ff, event_in;
   logic [bda_pkg::NUM_BUTTONS-1:0]      down_ff, down_in;
   logic [bda_pkg::NUM_BUTTONS-1:0]      locked_ff, locked_in;

   bda_pkg::lane_status_type             lane_status [bda_pkg::NUM_BUTTONS];
   logic                                 advance;
   logic                                 req_take;

   // the held item moves on when the result slot is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // settings writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.debounce_time <= bda_pkg::MS_CFG_W'(30);
         timing_ff.repeat_delay  <= bda_pkg::MS_CFG_W'(500);
         timing_ff.repeat_period <= bda_pkg::MS_CFG_W'(120);
         repeat_en_ff            <= bda_pkg::NUM_BUTTONS'(15);
      end else if (csr_we) begin
         unique case (bda_pkg::csr_index_type'(csr_index))
            bda_pkg::CSR_DEBOUNCE_TIME: timing_ff.debounce_time <= csr_wdata;
            bda_pkg::CSR_REPEAT_DELAY:  timing_ff.repeat_delay  <= csr_wdata;
            bda_pkg::CSR_REPEAT_PERIOD: timing_ff.repeat_period <= csr_wdata;
            bda_pkg::CSR_REPEAT_ENABLE: repeat_en_ff <= csr_wdata[bda_pkg::NUM_BUTTONS-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= bda_pkg::action_type'(req_action);
         s1_raw_ff    <= req_raw_pressed;
         s1_now_ff    <= req_now_ms;
      end
   end

   // one lane per button, all updated by the same item
   for (genvar g = 0; g < bda_pkg::NUM_BUTTONS; g++) begin : g_lane
      bda_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .update    (advance),
         .action    (s1_action_ff),
         .raw       (s1_raw_ff[g]),
         .now_ms    (s1_now_ff),
         .timing    (timing_ff),
         .repeat_en (repeat_en_ff[g]),
         .status    (lane_status[g])
      );
   end

   // lowest button that fired wins; scan from the top so the lowest is last
   always_comb begin
      event_in = bda_pkg::NO_EVENT;
      for (int i = bda_pkg::NUM_BUTTONS - 1; i >= 0; i--) begin
         down_in[i]   = lane_status[i].down;
         locked_in[i] = lane_status[i].locked;
         if (lane_status[i].fire) event_in = bda_pkg::EVENT_W'(i);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff  <= event_in;
         down_ff   <= down_in;
         locked_ff <= locked_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_button = event_ff;
   assign rsp_down_mask    = down_ff;
   assign rsp_locked_mask  = locked_ff;

   // a locked button is never reported as down
   `BDA_ASSERT_IMP(a_down_not_locked, rsp_valid_ff, (down_ff & locked_ff) == '0,
      "button reported down while locked")
   // a reported event belongs to a button that is now down
   `BDA_ASSERT_IMP(a_event_is_down, rsp_valid_ff && event_ff != bda_pkg::NO_EVENT,
      ((down_ff >> event_ff) & bda_pkg::NUM_BUTTONS'(1)) != '0,
      "event on a button that is not down")
   // a probe item never reports an event
   `BDA_ASSERT(a_probe_no_event,
      advance && s1_action_ff == bda_pkg::ACT_PROBE |=> event_ff == bda_pkg::NO_EVENT,
      "probe item produced an event")
   // stall only with an item held and the result slot blocked
   `BDA_ASSERT_IMP(a_stall_cause, req_stall, s1_valid_ff && rsp_valid_ff && rsp_stall,
      "input stalled without a blocked result")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the button debounce / autorepeat block
// ----------------------------------------------------------------------------
// Sends sampled button levels and startup probes with millisecond stamps.
// A scoreboard object tracks each button's debounce, autorepeat and
// startup-lock state and builds the expected report for every accepted item.
// Reports are compared field by field in order. The run first sends a short
// directed sequence, then eight phases of random press and release patterns
// with bounce and noise. Each phase uses its own timing settings and one
// of four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb;
   import bda_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 204;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE_TICKS = 4;    // margin after the last report

   // expected report of one item
   typedef struct packed {
      logic [EVENT_W-1:0]     event_button;
      logic [NUM_BUTTONS-1:0] down_mask;
      logic [NUM_BUTTONS-1:0] locked_mask;
   } button_report_type;

   // tracks button state and holds the reports still to come
   class debounce_scoreboard;
      bit [MS_CFG_W-1:0]    debounce_ms;
      bit [MS_CFG_W-1:0]    delay_ms;
      bit [MS_CFG_W-1:0]    period_ms;
      bit [NUM_BUTTONS-1:0] repeat_mask;
      bit [NUM_BUTTONS-1:0] held;
      bit [NUM_BUTTONS-1:0] last_level;
      bit [NUM_BUTTONS-1:0] locked;
      bit [TIME_W-1:0]      changed_at [NUM_BUTTONS];
      bit [TIME_W-1:0]      repeat_at  [NUM_BUTTONS];
      button_report_type    pending_reports [$];
      int                   errors;

      function new();
         debounce_ms = 30;
         delay_ms    = 500;
         period_ms   = 120;
         repeat_mask = 5'd15;
         held        = '0;
         last_level  = '0;
         locked      = '0;
         errors      = 0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            changed_at[i] = '0;
            repeat_at[i]  = '0;
         end
      endfunction

      function void apply_setting(csr_index_type idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_DEBOUNCE_TIME: debounce_ms = value;
            CSR_REPEAT_DELAY:  delay_ms    = value;
            CSR_REPEAT_PERIOD: period_ms   = value;
            CSR_REPEAT_ENABLE: repeat_mask = value[NUM_BUTTONS-1:0];
            default: ;
         endcase
      endfunction

      function void note_item(action_type act, bit [NUM_BUTTONS-1:0] raw,
                              bit [TIME_W-1:0] stamp);
         bit [EVENT_W-1:0]  fired;
         bit [TIME_W-1:0]   age;
         bit                level;
         button_report_type rep;
         fired = NO_EVENT;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            level = raw[i];
            if (act == ACT_PROBE) begin
               if (level) begin
                  locked[i]     = 1'b1;
                  last_level[i] = 1'b1;
               end
            end else if (level != last_level[i]) begin
               last_level[i] = level;
               changed_at[i] = stamp;
            end else begin
               age = stamp - changed_at[i];
               if (age >= TIME_W'(debounce_ms)) begin
                  if (locked[i]) begin
                     if (!level) locked[i] = 1'b0;
                  end else if (level && !held[i]) begin
                     held[i]      = 1'b1;
                     repeat_at[i] = stamp + TIME_W'(delay_ms);
                     if (fired == NO_EVENT) fired = EVENT_W'(i);
                  end else if (!level && held[i]) begin
                     held[i] = 1'b0;
                  end else if (level && held[i] && repeat_mask[i]) begin
                     // plain unsigned compare, no wrap handling
                     if (stamp >= repeat_at[i]) begin
                        repeat_at[i] = stamp + TIME_W'(period_ms);
                        if (fired == NO_EVENT) fired = EVENT_W'(i);
                     end
                  end
               end
            end
         end
         rep.event_button = fired;
         rep.down_mask    = held & ~locked;
         rep.locked_mask  = locked;
         pending_reports.push_back(rep);
      endfunction

      function void check_report(logic [EVENT_W-1:0] ev, logic [NUM_BUTTONS-1:0] down,
                                 logic [NUM_BUTTONS-1:0] lk);
         button_report_type exp_rep;
         if (pending_reports.size() == 0) begin
            $error("report with no item outstanding: event_button %0d", ev);
            errors++;
            return;
         end
         exp_rep = pending_reports.pop_front();
         if (ev !== exp_rep.event_button) begin
            $error("event_button: expected %0d, got %0d", exp_rep.event_button, ev);
            errors++;
         end
         if (down !== exp_rep.down_mask) begin
            $error("down_mask: expected %b, got %b", exp_rep.down_mask, down);
            errors++;
         end
         if (lk !== exp_rep.locked_mask) begin
            $error("locked_mask: expected %b, got %b", exp_rep.locked_mask, lk);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_reports.size();
      endfunction
   endclass

   // dut ports; the inputs are known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [1:0]             csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_action = 1'b0;
   logic [NUM_BUTTONS-1:0] req_raw_pressed = '0;
   logic [TIME_W-1:0]      req_now_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [EVENT_W-1:0]     rsp_event_button;
   logic [NUM_BUTTONS-1:0] rsp_down_mask;
   logic [NUM_BUTTONS-1:0] rsp_locked_mask;

   debounce_scoreboard board = new();

   // traffic shaping, set per phase
   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct       = 0;
   logic        holding         = 1'b0;   // long receiver hold-off in progress
   int unsigned cycle_count     = 0;

   // stimulus state: running stamp and the level pattern being held
   bit [TIME_W-1:0]      stamp_ms = '0;
   bit [NUM_BUTTONS-1:0] target_mask = '0;

   button_debounce_autorepeat dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_raw_pressed  (req_raw_pressed),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_down_mask    (rsp_down_mask),
      .rsp_locked_mask  (rsp_locked_mask)
   );

   always #10 clock = ~clock;

   // result side: check on handshake, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_report(rsp_event_button, rsp_down_mask, rsp_locked_mask);
      rsp_stall <= holding || ($urandom_range(99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // offer one item, hold it until taken
   task automatic send_item(input action_type act, input bit [NUM_BUTTONS-1:0] raw,
                            input bit [TIME_W-1:0] stamp);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_raw_pressed <= raw;
      req_now_ms      <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(act, raw, stamp);
   endtask

   // wait for every report, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // all four registers, back to back, only while idle
   task automatic write_settings(input bit [15:0] debounce, input bit [15:0] delay,
                                 input bit [15:0] period, input bit [4:0] mask);
      csr_index_type idx;
      bit [CSR_DATA_W-1:0] vals [4];
      vals[0] = debounce;
      vals[1] = delay;
      vals[2] = period;
      vals[3] = CSR_DATA_W'(mask);
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
         board.apply_setting(idx, vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   // press/hold/release patterns with bounce, plus noise and probes
   task automatic run_patterns(input int count);
      int unsigned span;
      int unsigned step_cap;
      int          hold_left;
      int          bounce_left;
      int unsigned kind;
      bit [NUM_BUTTONS-1:0] raw;
      // time steps scale with the current settings so holds outlast debounce
      span = 32'(board.debounce_ms);
      if (32'(board.period_ms) > span) span = 32'(board.period_ms);
      if (32'(board.delay_ms / 4) > span) span = 32'(board.delay_ms / 4);
      step_cap    = span / 4 + 2;
      hold_left   = 0;
      bounce_left = 0;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 3) begin
            // probe at any moment
            send_item(ACT_PROBE, NUM_BUTTONS'($urandom), stamp_ms);
         end else if (kind < 12) begin
            // noise: random levels, sometimes a jump anywhere in time
            if ($urandom_range(3) == 0) stamp_ms = $urandom;
            send_item(ACT_UPDATE, NUM_BUTTONS'($urandom), stamp_ms);
         end else begin
            if (hold_left == 0) begin
               case ($urandom_range(3))
                  0: target_mask = '0;
                  1: target_mask = NUM_BUTTONS'(1) << $urandom_range(NUM_BUTTONS - 1);
                  2: target_mask = NUM_BUTTONS'($urandom);
                  default: target_mask[$urandom_range(NUM_BUTTONS - 1)] ^= 1'b1;
               endcase
               hold_left   = $urandom_range(4, 60);
               bounce_left = $urandom_range(0, 4);
            end
            raw = target_mask;
            if (bounce_left > 0) begin
               raw ^= NUM_BUTTONS'($urandom);
               bounce_left--;
            end
            hold_left--;
            stamp_ms += $urandom_range(0, step_cap);
            send_item(ACT_UPDATE, raw, stamp_ms);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset settings (debounce 30, delay 500, period 120, mask 01111)
      send_item(ACT_UPDATE, 5'b00000, 32'd0);
      send_item(ACT_PROBE,  5'b10101, 32'd5);         // lock buttons 0, 2, 4
      send_item(ACT_UPDATE, 5'b11111, 32'd10);        // edges on 1 and 3
      send_item(ACT_UPDATE, 5'b11111, 32'd50);        // press 1 and 3, locked ones stay
      send_item(ACT_PROBE,  5'b00000, 32'd55);        // probe with nothing pressed
      send_item(ACT_PROBE,  5'b00010, 32'd56);        // lock a held button
      send_item(ACT_UPDATE, 5'b00000, 32'd60);        // release edges
      send_item(ACT_UPDATE, 5'b00000, 32'd100);       // unlock 0, 1, 2, 4; button 1 keeps held, 3 releases
      send_item(ACT_UPDATE, 5'b00000, 32'd200);       // now the release of button 1 counts
      send_item(ACT_UPDATE, 5'b11111, 32'hFFFF_FFF0);
      send_item(ACT_UPDATE, 5'b11111, 32'h0000_0020); // age wraps past zero
      send_item(ACT_UPDATE, 5'b11111, 32'hFFFF_FFFF); // age still below debounce, no change
      send_item(ACT_UPDATE, 5'b11111, 32'h0000_0030); // repeat time not yet reached, no event
      send_item(ACT_UPDATE, 5'b11111, 32'h0000_0080);
      send_item(ACT_UPDATE, 5'b10000, 32'h0000_0090); // button 4 has no repeat
      send_item(ACT_UPDATE, 5'b10000, 32'h0000_0200);
      send_item(ACT_UPDATE, 5'b00000, 32'h0000_0210);
      send_item(ACT_UPDATE, 5'b00000, 32'h0000_0300);
      send_item(ACT_UPDATE, 5'b00001, 32'h0000_0400);
      send_item(ACT_UPDATE, 5'b00001, 32'h0000_041D); // one short of debounce
      send_item(ACT_UPDATE, 5'b00001, 32'h0000_041E); // exactly debounce
      send_item(ACT_UPDATE, 5'b00000, 32'h0000_0500);
      send_item(ACT_UPDATE, 5'b00000, 32'h0000_0600);
      stamp_ms = 32'h0000_1000;
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         // settings per phase, extremes included
         case (phase)
            0: write_settings(16'd30, 16'd500, 16'd120, 5'd15);
            1: write_settings(16'd0, 16'd0, 16'd0, 5'd31);
            2: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd0);
            4: write_settings(16'd0, 16'hFFFF, 16'd1, 5'd31);
            5: write_settings(16'hFFFF, 16'($urandom_range(0, 2000)),
                              16'($urandom_range(1, 50)), 5'd31);
            default: write_settings(16'($urandom_range(1, 60)), 16'($urandom_range(0, 700)),
                                    16'($urandom_range(0, 250)), 5'($urandom));
         endcase
         // gap mix: none, sender, receiver, both
         case (phase % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 73; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 73; end
            default: begin sender_idle_pct = 6; stall_pct = 6; end
         endcase
         // some phases start just below the wrap of the stamp
         if (phase == 2 || phase == 5) stamp_ms = 32'hFFFF_FFFF - $urandom_range(20000);

         if (phase == 0) begin
            // receiver holds off while items keep coming, fills the block
            fork
               begin
                  holding <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  holding <= 1'b0;
               end
               run_patterns(PHASE_ITEMS / 2);
            join
            run_patterns(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            run_patterns(PHASE_ITEMS);
         end
         drain();
      end

      if (board.errors == 0 && board.outstanding() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/bda_pkg.sv
rtl/bda_lane.sv
rtl/button_debounce_autorepeat.sv
sim/tb.sv
